FILE: rtl/core/row_displacement_table_packer_core_macros.svh
// ----------------------------------------------------------------------------
// Row displacement table packer: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ROW_DISPLACEMENT_TABLE_PACKER_CORE_MACROS_SVH
`define ROW_DISPLACEMENT_TABLE_PACKER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RDTP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define RDTP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/rdtp_pkg.sv
// ----------------------------------------------------------------------------
// rdtp_pkg
// Types and constants shared by the row displacement table packer.
// ----------------------------------------------------------------------------
`default_nettype none

package rdtp_pkg;

    // table geometry
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int TABLE_SLOTS = 4096;

    localparam int ROW_AW  = $clog2(MAX_ROWS);
    localparam int COL_AW  = $clog2(MAX_COLS);
    localparam int SLOT_AW = $clog2(TABLE_SLOTS);
    localparam int TAB_W   = SLOT_AW + 1;

    // field widths
    localparam int CNT_W   = 7;
    localparam int VAL_W   = 16;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_READ   = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_RANGE    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_FIT_RD,
        ST_FIT_CHK,
        ST_PLACE_RD,
        ST_PLACE_WR,
        ST_RD_REQ,
        ST_RD_WAIT,
        ST_LK_REQ,
        ST_LK_BASE,
        ST_LK_WAIT,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // one input beat
    typedef struct packed {
        kind_t                    kind;
        logic [CNT_W-1:0]         row;
        logic [CNT_W-1:0]         col;
        logic [VAL_W-1:0]         val;
        logic [SLOT_AW-1:0]       slot;
    } cmd_t;

    // effective matrix size
    typedef struct packed {
        logic [CNT_W-1:0] rows;
        logic [CNT_W-1:0] cols;
    } geom_t;

    // one result beat
    typedef struct packed {
        status_t            status;
        logic [SLOT_AW-1:0] base;
        logic [VAL_W-1:0]   value;
        logic [CNT_W-1:0]   owner;
        logic [TAB_W-1:0]   highest;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/rdtp_ram.sv
// ----------------------------------------------------------------------------
// rdtp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rdtp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/rdtp_ctrl.sv
// ----------------------------------------------------------------------------
// rdtp_ctrl
// Sequencer over the slot, base and row buffer memories.
// ----------------------------------------------------------------------------
`default_nettype none

module rdtp_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire rdtp_pkg::cmd_t cmd,
    output logic                cmd_ready,
    input  wire rdtp_pkg::geom_t geom,
    output logic                res_valid,
    input  wire logic           res_ready,
    output rdtp_pkg::res_t      res
);

    import rdtp_pkg::*;

    localparam int SLOT_DW = VAL_W + CNT_W;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    res_t               res_reg, res_next;
    logic [SLOT_AW-1:0] base_reg, base_next;
    logic [TAB_W-1:0]   limit_reg, limit_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [TAB_W-1:0]   highest_reg, highest_next;
    logic [SLOT_AW-1:0] clr_reg, clr_next;
    logic [TAB_W-1:0]   idx_reg, idx_next;

    // memory ports
    logic               s_we, b_we, r_we;
    logic [SLOT_AW-1:0] s_waddr, s_raddr;
    logic [SLOT_DW-1:0] s_wdata, s_q;
    logic [ROW_AW-1:0]  b_waddr, b_raddr;
    logic [SLOT_AW-1:0] b_wdata, b_q;
    logic [COL_AW-1:0]  r_waddr, r_raddr;
    logic [VAL_W-1:0]   r_wdata, r_q;

    logic               acc, rc_ok, conflict, last_col, hit;
    logic [2*CNT_W-1:0] prod;
    logic [TAB_W-1:0]   slots, limit, sum_bj, lk_idx;
    logic [VAL_W-1:0]   s_val;
    logic [CNT_W-1:0]   s_own;

    rdtp_ram #(.WIDTH(SLOT_DW), .DEPTH(TABLE_SLOTS)) u_slot_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_q)
    );

    rdtp_ram #(.WIDTH(SLOT_AW), .DEPTH(MAX_ROWS)) u_base_ram (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_q)
    );

    rdtp_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_row_ram (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_q)
    );

    // shared decode
    always_comb
    begin
        acc      = cmd_valid && cmd_ready;
        rc_ok    = (cmd.row != '0) && (cmd.row <= geom.rows) &&
                   (cmd.col != '0) && (cmd.col <= geom.cols);
        prod     = geom.rows * geom.cols;
        slots    = (prod > (2*CNT_W)'(TABLE_SLOTS)) ? TAB_W'(TABLE_SLOTS)
                                                    : prod[TAB_W-1:0];
        limit    = (slots > TAB_W'(geom.cols)) ? slots - TAB_W'(geom.cols) : '0;
        sum_bj   = TAB_W'(base_reg) + TAB_W'(j_reg);
        lk_idx   = TAB_W'(b_q) + TAB_W'(cmd_reg.col) - TAB_W'(1);
        s_val    = s_q[VAL_W-1:0];
        s_own    = s_q[SLOT_DW-1:VAL_W];
        conflict = (r_q != '0) && (s_own != '0);
        last_col = (j_reg == geom.cols - CNT_W'(1));
        hit      = (idx_reg < highest_reg) && (idx_reg < TAB_W'(TABLE_SLOTS)) &&
                   (s_own == cmd_reg.row);
    end

    // next state and datapath registers
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        res_next     = res_reg;
        base_next    = base_reg;
        limit_next   = limit_reg;
        j_next       = j_reg;
        highest_next = highest_reg;
        clr_next     = clr_reg;
        idx_next     = idx_reg;
        case (state_reg)
            ST_INIT:
            begin
                clr_next = clr_reg + SLOT_AW'(1);
                if (clr_reg == '1)
                begin
                    highest_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    case (cmd.kind)
                        KIND_LOAD:
                        begin
                            if (!rc_ok)
                            begin
                                res_next.status = STAT_RANGE;
                                state_next      = ST_DONE;
                            end
                            else if (cmd.col == geom.cols)
                            begin
                                base_next  = '0;
                                j_next     = '0;
                                limit_next = limit;
                                if (geom.rows == CNT_W'(1))
                                begin
                                    state_next = ST_PLACE_RD;
                                end
                                else if (limit == '0)
                                begin
                                    res_next.status = STAT_OVERFLOW;
                                    state_next      = ST_DONE;
                                end
                                else
                                begin
                                    state_next = ST_FIT_RD;
                                end
                            end
                        end
                        KIND_READ:
                        begin
                            if (TAB_W'(cmd.slot) >= TAB_W'(TABLE_SLOTS))
                            begin
                                res_next.status = STAT_RANGE;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_RD_REQ;
                            end
                        end
                        KIND_LOOKUP:
                        begin
                            if (!rc_ok)
                            begin
                                res_next.status = STAT_RANGE;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_LK_REQ;
                            end
                        end
                        default:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_FIT_RD:
            begin
                state_next = ST_FIT_CHK;
            end
            ST_FIT_CHK:
            begin
                if (conflict)
                begin
                    if (TAB_W'(base_reg) + TAB_W'(1) == limit_reg)
                    begin
                        res_next.status = STAT_OVERFLOW;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        base_next  = base_reg + SLOT_AW'(1);
                        j_next     = '0;
                        state_next = ST_FIT_RD;
                    end
                end
                else if (last_col)
                begin
                    j_next     = '0;
                    state_next = ST_PLACE_RD;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = ST_FIT_RD;
                end
            end
            ST_PLACE_RD:
            begin
                state_next = ST_PLACE_WR;
            end
            ST_PLACE_WR:
            begin
                if ((r_q != '0) && (sum_bj + TAB_W'(1) > highest_reg))
                begin
                    highest_next = sum_bj + TAB_W'(1);
                end
                if (last_col)
                begin
                    res_next.status = STAT_OK;
                    res_next.base   = base_reg;
                    state_next      = ST_DONE;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = ST_PLACE_RD;
                end
            end
            ST_RD_REQ:
            begin
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                res_next.value = s_val;
                res_next.owner = s_own;
                state_next     = ST_DONE;
            end
            ST_LK_REQ:
            begin
                state_next = ST_LK_BASE;
            end
            ST_LK_BASE:
            begin
                base_next  = b_q;
                idx_next   = lk_idx;
                state_next = ST_LK_WAIT;
            end
            ST_LK_WAIT:
            begin
                res_next.base  = base_reg;
                res_next.value = hit ? s_val : '0;
                state_next     = ST_DONE;
            end
            ST_CLEAR:
            begin
                clr_next = clr_reg + SLOT_AW'(1);
                if (clr_reg == '1)
                begin
                    highest_next = '0;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory controls and handshake outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        res_valid = 1'b0;
        s_we      = 1'b0;
        s_waddr   = sum_bj[SLOT_AW-1:0];
        s_wdata   = {cmd_reg.row, r_q};
        s_raddr   = sum_bj[SLOT_AW-1:0];
        b_we      = 1'b0;
        b_waddr   = ROW_AW'(cmd_reg.row - CNT_W'(1));
        b_wdata   = base_reg;
        b_raddr   = ROW_AW'(cmd_reg.row - CNT_W'(1));
        r_we      = 1'b0;
        r_waddr   = COL_AW'(cmd.col - CNT_W'(1));
        r_wdata   = cmd.val;
        r_raddr   = j_reg[COL_AW-1:0];
        res       = res_reg;
        res.highest = highest_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                r_we      = acc && (cmd.kind == KIND_LOAD) && rc_ok;
            end
            ST_PLACE_WR:
            begin
                s_we = (r_q != '0);
                b_we = (j_reg == '0);
            end
            ST_RD_REQ:
            begin
                s_raddr = cmd_reg.slot;
            end
            ST_LK_BASE:
            begin
                s_raddr = lk_idx[SLOT_AW-1:0];
            end
            ST_INIT, ST_CLEAR:
            begin
                s_we    = 1'b1;
                s_waddr = clr_reg;
                s_wdata = '0;
                b_we    = 1'b1;
                b_waddr = clr_reg[ROW_AW-1:0];
                b_wdata = '0;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            clr_reg     <= '0;
            highest_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            highest_reg <= highest_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        base_reg  <= base_next;
        limit_reg <= limit_next;
        j_reg     <= j_next;
        idx_reg   <= idx_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/row_displacement_table_packer_core.sv
// ----------------------------------------------------------------------------
// row_displacement_table_packer_core
// First-fit row displacement packer with APB configuration and stream ports.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 4096-slot table with s_tready low. A
// load that is not the last column of a row gives no beat. A row end
// tries bases in order, checking each column's slot per base (up to the
// first conflict), then writes the row; the slot memory's single read
// port sets this pace. A read passes request and wait states, a lookup
// request, base and wait states; a clear sweeps the table. One beat is in
// flight at a time; a finished beat waits in the output register.
`default_nettype none

module row_displacement_table_packer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // row_index, col_index, elem_value, slot_index, zero pad
    input  wire logic [rdtp_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status, row_base, out_value, owner_row, highest_used, zero pad
    output logic [rdtp_pkg::M_TDATA_W-1:0] m_tdata
);

    import rdtp_pkg::*;

    localparam logic [2:0] ADDR_ROW_COUNT = 3'd0;
    localparam logic [2:0] ADDR_COL_COUNT = 3'd4;

    logic [CNT_W-1:0]     row_count_reg, col_count_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 cfg_wr, res_valid, res_ready, res_take;
    cmd_t                 cmd;
    geom_t                geom;
    res_t                 res;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CNT_W'(MAX_ROWS);
            col_count_reg <= CNT_W'(MAX_COLS);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ADDR_COL_COUNT[2])
            begin
                col_count_reg <= pwdata[CNT_W-1:0];
            end
            else
            begin
                row_count_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_ROW_COUNT: prdata = 32'(row_count_reg);
            ADDR_COL_COUNT: prdata = 32'(col_count_reg);
            default:        prdata = '0;
        endcase
    end

    // saturate to the supported matrix size
    always_comb
    begin
        geom.rows = (row_count_reg == '0) ? CNT_W'(1) :
                    (row_count_reg > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_count_reg;
        geom.cols = (col_count_reg == '0) ? CNT_W'(1) :
                    (col_count_reg > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : col_count_reg;
    end

    // unpack input beat
    always_comb
    begin
        cmd.kind = kind_t'(s_tuser);
        cmd.row  = s_tdata[6:0];
        cmd.col  = s_tdata[13:7];
        cmd.val  = s_tdata[29:14];
        cmd.slot = s_tdata[41:30];
    end

    rdtp_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(s_tvalid),
        .cmd(cmd),
        .cmd_ready(s_tready),
        .geom(geom),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_tready;
    assign res_take  = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            m_data_reg <= {6'b0, res.highest, res.owner, res.value, res.base, res.status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rdtp_checker.sv
// ----------------------------------------------------------------------------
// rdtp_checker
// Port-level checks for the row displacement table packer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "row_displacement_table_packer_core_macros.svh"

module rdtp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);

    // a held beat stays up
    `RDTP_ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // a held beat keeps its payload
    `RDTP_ASSERT_NXT(a_data_hold, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))

    // status code is never the unused one
    `RDTP_ASSERT_IMP(a_status, clk, rst_n, m_tvalid, m_tdata[1:0] != 2'd3)

    // high-water mark within the table
    `RDTP_ASSERT_IMP(a_highest, clk, rst_n, m_tvalid, m_tdata[49:37] <= 13'd4096)

endmodule

bind row_displacement_table_packer_core rdtp_checker u_rdtp_checker (.*);

`default_nettype wire
